// ===== rtl/core/frm_pkg.sv =====
// Shared types and constants for the ring-buffer FIR filter.
// Used by frm_ctrl, frm_store, frm_mac and fir_filter_ring_mac.
package frm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int COEF_IDX_W  = 5;
    localparam int TAP_CNT_W   = 6;
    localparam int PROD_W      = 32;
    localparam int ACC_W       = 40;
    localparam int OUT_W       = 16;
    localparam int IN_DATA_W   = 40;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RESET = 6'd32;
    localparam logic                 REG_TAP_COUNT   = 1'b0;

    localparam logic signed [OUT_W-1:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [OUT_W-1:0] SAT_MIN = 16'sh8000;

    typedef enum logic
    {
        ACT_SAMPLE = 1'b0,
        ACT_COEF   = 1'b1
    } frm_action_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_REDUCE,
        ST_WRITE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND
    } frm_state_t;

    typedef struct packed
    {
        logic coef_we;
        logic hist_we;
        logic rd_en;
        logic acc_clr;
        logic res_load;
    } frm_ctrl_t;

    typedef struct packed
    {
        logic pipe_busy;
        logic out_free;
    } frm_stat_t;

endpackage

// ===== rtl/core/frm_store.sv =====
// Coefficient table and sample ring, one port each, registered read data.
// Depends on frm_pkg.
module frm_store
    import frm_pkg::*;
#(
    parameter int MAX_TAPS = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  frm_ctrl_t                         ctrl,
    input  logic [$clog2(MAX_TAPS)-1:0]       coef_addr,
    input  logic [$clog2(MAX_TAPS)-1:0]       hist_addr,
    input  logic [SAMPLE_W-1:0]               wr_data,
    output logic signed [COEF_W-1:0]          coef_rd,
    output logic signed [SAMPLE_W-1:0]        hist_rd,
    output logic                              rd_valid
);

    logic [COEF_W-1:0]   coef_mem [MAX_TAPS];
    logic [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0] coef_vld_reg;
    logic [MAX_TAPS-1:0] hist_vld_reg;
    logic [COEF_W-1:0]   coef_rd_reg;
    logic [SAMPLE_W-1:0] hist_rd_reg;
    logic                rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.coef_we)
        begin
            coef_mem[coef_addr] <= wr_data;
        end
        if (ctrl.hist_we)
        begin
            hist_mem[hist_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            coef_rd_reg <= coef_vld_reg[coef_addr] ? coef_mem[coef_addr] : '0;
            hist_rd_reg <= hist_vld_reg[hist_addr] ? hist_mem[hist_addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg <= '0;
            hist_vld_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.coef_we)
            begin
                coef_vld_reg[coef_addr] <= 1'b1;
            end
            if (ctrl.hist_we)
            begin
                hist_vld_reg[hist_addr] <= 1'b1;
            end
            rd_valid_reg <= ctrl.rd_en;
        end
    end

    assign coef_rd  = $signed(coef_rd_reg);
    assign hist_rd  = $signed(hist_rd_reg);
    assign rd_valid = rd_valid_reg;

endmodule

// ===== rtl/core/frm_mac.sv =====
// Shared multiply-accumulate, rounding, saturation and the output register.
// Depends on frm_pkg.
module frm_mac
    import frm_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 15
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  frm_ctrl_t                   ctrl,
    input  logic signed [COEF_W-1:0]    coef_rd,
    input  logic signed [SAMPLE_W-1:0]  hist_rd,
    input  logic                        rd_valid,
    output frm_stat_t                   stat,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [OUT_W-1:0]            sample_out,
    output logic                        saturated
);

    localparam int SUM_W = ACC_W + 1;
    localparam logic [SUM_W-1:0] ROUND_ADD =
        {{(SUM_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    logic [OUT_W-1:0]         sample_out_reg;
    logic                     saturated_reg;

    logic [SUM_W-1:0]         sum;
    logic signed [SUM_W-1:0]  shifted;
    logic                     sat_hi;
    logic                     sat_lo;
    logic [OUT_W-1:0]         y;

    always_ff @(posedge clk)
    begin
        if (rd_valid)
        begin
            prod_reg <= coef_rd * hist_rd;
        end
        if (ctrl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (ctrl.res_load)
        begin
            sample_out_reg <= y;
            saturated_reg  <= sat_hi | sat_lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= rd_valid;
            if (ctrl.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sum     = {acc_reg[ACC_W-1], acc_reg} + ROUND_ADD;
        shifted = $signed(sum) >>> COEF_FRAC_BITS;
        sat_hi  = ~shifted[SUM_W-1] & (|shifted[SUM_W-2:OUT_W-1]);
        sat_lo  = shifted[SUM_W-1] & ~(&shifted[SUM_W-2:OUT_W-1]);
        priority if (sat_hi)
        begin
            y = SAT_MAX;
        end
        else if (sat_lo)
        begin
            y = SAT_MIN;
        end
        else
        begin
            y = shifted[OUT_W-1:0];
        end
    end

    assign stat.pipe_busy = rd_valid | prod_valid_reg;
    assign stat.out_free  = ~out_valid_reg | out_ready;
    assign out_valid      = out_valid_reg;
    assign sample_out     = sample_out_reg;
    assign saturated      = saturated_reg;

endmodule

// ===== rtl/core/frm_ctrl.sv =====
// Sequencer: input transactions, ring pointer, tap walk and result hand-off.
// Depends on frm_pkg.
module frm_ctrl
    import frm_pkg::*;
#(
    parameter int MAX_TAPS = 32
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             action,
    input  logic [SAMPLE_W-1:0]              sample_in,
    input  logic [COEF_IDX_W-1:0]            coef_index,
    input  logic [COEF_W-1:0]                coef_value,
    input  logic [TAP_CNT_W-1:0]             tap_count,
    input  frm_stat_t                        stat,
    output frm_ctrl_t                        ctrl,
    output logic [$clog2(MAX_TAPS)-1:0]      coef_addr,
    output logic [$clog2(MAX_TAPS)-1:0]      hist_addr,
    output logic [SAMPLE_W-1:0]              wr_data
);

    localparam int PTR_W = $clog2(MAX_TAPS);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int CMP_W = (CNT_W > TAP_CNT_W) ? CNT_W : TAP_CNT_W;
    localparam int IDX_W = (PTR_W > COEF_IDX_W) ? PTR_W : COEF_IDX_W;

    frm_state_t           state_reg, state_next;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [PTR_W-1:0]     i_reg, i_next;
    logic [PTR_W-1:0]     k_reg, k_next;
    logic [SAMPLE_W-1:0]  sample_reg, sample_next;

    logic [CMP_W-1:0]     tap_wide;
    logic [CNT_W-1:0]     n_clamp;
    logic [CNT_W-1:0]     n_last;
    logic [CNT_W-1:0]     ptr_wide;
    logic [IDX_W:0]       cidx_wide;
    logic                 cidx_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        i_reg      <= i_next;
        k_reg      <= k_next;
        sample_reg <= sample_next;
    end

    always_comb
    begin
        tap_wide  = CMP_W'(tap_count);
        priority if (tap_count == '0)
        begin
            n_clamp = CNT_W'(1);
        end
        else if (tap_wide > CMP_W'(MAX_TAPS))
        begin
            n_clamp = CNT_W'(MAX_TAPS);
        end
        else
        begin
            n_clamp = CNT_W'(tap_wide);
        end
        n_last    = n_reg - CNT_W'(1);
        ptr_wide  = CNT_W'(ptr_reg);
        cidx_wide = (IDX_W + 1)'(coef_index);
        cidx_ok   = cidx_wide < (IDX_W + 1)'(MAX_TAPS);

        state_next  = state_reg;
        ptr_next    = ptr_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        sample_next = sample_reg;
        ctrl        = '0;
        coef_addr   = i_reg;
        hist_addr   = k_reg;
        wr_data     = sample_reg;
        in_ready    = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                coef_addr = PTR_W'(cidx_wide);
                wr_data   = coef_value;
                if (in_valid)
                begin
                    if (action == ACT_COEF)
                    begin
                        ctrl.coef_we = cidx_ok;
                    end
                    else
                    begin
                        sample_next = sample_in;
                        n_next      = n_clamp;
                        state_next  = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (ptr_wide >= n_reg)
                begin
                    ptr_next = PTR_W'(ptr_wide - n_reg);
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                hist_addr    = ptr_reg;
                ctrl.hist_we = 1'b1;
                ctrl.acc_clr = 1'b1;
                i_next       = '0;
                k_next       = ptr_reg;
                state_next   = ST_MAC;
            end
            ST_MAC:
            begin
                ctrl.rd_en = 1'b1;
                i_next     = i_reg + PTR_W'(1);
                k_next     = (k_reg == '0) ? PTR_W'(n_last) : k_reg - PTR_W'(1);
                if (CNT_W'(i_reg) == n_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (stat.out_free)
                begin
                    ctrl.res_load = 1'b1;
                    ptr_next      = (ptr_wide == n_last) ? '0 : ptr_reg + PTR_W'(1);
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/fir_filter_ring_mac.sv =====
// Top level of the ring-buffer FIR filter: stream ports, APB register, core.
// Depends on frm_pkg, frm_ctrl, frm_store and frm_mac.
//
// Direct-form FIR filter with one shared 16x16 multiply-accumulate. A sample
// transaction (tuser = 0) stores the sample in a ring of past samples, sums
// coefficient[i] times the sample i steps back over n taps in a 40-bit
// accumulator, rounds half up, shifts right by COEF_FRAC_BITS and saturates to
// 16 bits; tuser on the output flags saturation. A coefficient transaction
// (tuser = 1) writes one coefficient and gives no result. The input is not
// ready while a sample is in work. The multiply-accumulate walks one tap per
// cycle through its three-stage pipeline; n is tap_count clamped to
// 1..MAX_TAPS. After tap_count is lowered to or below the ring pointer, the
// pointer is first folded back into the ring by repeated subtraction of n. A
// coefficient write completes as it is accepted and leaves the input ready. A
// finished result waits in an output register, so the next sample is accepted
// while it is still held. No clearing pass after reset is needed.
module fir_filter_ring_mac
    import frm_pkg::*;
#(
    parameter int MAX_TAPS       = 32,
    parameter int COEF_FRAC_BITS = 15
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // sample_in[15:0], coef_index[20:16], coef_value[36:21], zero[39:37]
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    // action[0]
    input  logic                    s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // sample_out[15:0]
    output logic [OUT_W-1:0]        m_axis_tdata,
    // saturated[0]
    output logic                    m_axis_tuser,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    localparam int PTR_W = $clog2(MAX_TAPS);

    logic [TAP_CNT_W-1:0]    tap_count_reg;
    logic                    cfg_write;

    frm_ctrl_t               ctrl;
    frm_stat_t               stat;
    logic [PTR_W-1:0]        coef_addr;
    logic [PTR_W-1:0]        hist_addr;
    logic [SAMPLE_W-1:0]     wr_data;
    logic signed [COEF_W-1:0]   coef_rd;
    logic signed [SAMPLE_W-1:0] hist_rd;
    logic                    rd_valid;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == REG_TAP_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            tap_count_reg <= pwdata[TAP_CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TAP_COUNT) ? APB_DATA_W'(tap_count_reg) : '0;

    frm_ctrl #(
        .MAX_TAPS   (MAX_TAPS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .action     (s_axis_tuser),
        .sample_in  (s_axis_tdata[15:0]),
        .coef_index (s_axis_tdata[20:16]),
        .coef_value (s_axis_tdata[36:21]),
        .tap_count  (tap_count_reg),
        .stat       (stat),
        .ctrl       (ctrl),
        .coef_addr  (coef_addr),
        .hist_addr  (hist_addr),
        .wr_data    (wr_data)
    );

    frm_store #(
        .MAX_TAPS   (MAX_TAPS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .coef_addr  (coef_addr),
        .hist_addr  (hist_addr),
        .wr_data    (wr_data),
        .coef_rd    (coef_rd),
        .hist_rd    (hist_rd),
        .rd_valid   (rd_valid)
    );

    frm_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .coef_rd    (coef_rd),
        .hist_rd    (hist_rd),
        .rd_valid   (rd_valid),
        .stat       (stat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .sample_out (m_axis_tdata),
        .saturated  (m_axis_tuser)
    );

endmodule
